/* hw/rtl/unary_bit_primitive_unit_macros.svh */
// ----------------------------------------------------------------------------
// Unary bit primitive unit assertion macros
// Shared assertion shorthands for the checker of the unit.
// ----------------------------------------------------------------------------
`ifndef UNARY_BIT_PRIMITIVE_UNIT_MACROS_SVH
`define UNARY_BIT_PRIMITIVE_UNIT_MACROS_SVH

// Checks a property on a given clock, disabled while the given reset is low.
`define UBPU_ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks a property on the unit clock and reset.
`define UBPU_ASSERT(label, prop, msg) \
  `UBPU_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

/* hw/rtl/ubpu_pkg.sv */
// ----------------------------------------------------------------------------
// Unary bit primitive unit package
// Request and response types, operation codes, mix constants and the
// byte-wide counting helpers.
// ----------------------------------------------------------------------------
package ubpu_pkg;

  localparam int DataW     = 64;
  localparam int OpW       = 3;
  localparam int CntW      = 7;
  localparam int ChunkW    = 8;
  localparam int NumChunks = DataW / ChunkW;
  localparam int ChunkCntW = 4;
  localparam int NumStages = 5;

  localparam logic [DataW-1:0] MixGamma = 64'h9e3779b97f4a7c15;
  localparam logic [DataW-1:0] MixMul1  = 64'hbf58476d1ce4e5b9;
  localparam logic [DataW-1:0] MixMul2  = 64'h94d049bb133111eb;
  localparam int MixShift1 = 30;
  localparam int MixShift2 = 27;
  localparam int MixShift3 = 31;

  typedef enum logic [OpW-1:0] {
    OpIlog2    = 3'd0,
    OpBitWidth = 3'd1,
    OpPopcount = 3'd2,
    OpClz      = 3'd3,
    OpCtz      = 3'd4,
    OpMix64    = 3'd5
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] operand_value;
    logic             in_last;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             out_last;
  } rsp_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  function automatic logic [ChunkCntW-1:0] lz8(logic [ChunkW-1:0] b);
    logic [ChunkCntW-1:0] n;
    logic                 hit;
    n   = ChunkCntW'(ChunkW);
    hit = 1'b0;
    for (int i = ChunkW - 1; i >= 0; i--) begin
      if (!hit && b[i]) begin
        n   = ChunkCntW'(ChunkW - 1 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [ChunkCntW-1:0] tz8(logic [ChunkW-1:0] b);
    logic [ChunkCntW-1:0] n;
    logic                 hit;
    n   = ChunkCntW'(ChunkW);
    hit = 1'b0;
    for (int i = 0; i < ChunkW; i++) begin
      if (!hit && b[i]) begin
        n   = ChunkCntW'(i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [ChunkCntW-1:0] pop8(logic [ChunkW-1:0] b);
    logic [ChunkCntW-1:0] n;
    n = '0;
    for (int i = 0; i < ChunkW; i++) begin
      n = n + ChunkCntW'(b[i]);
    end
    return n;
  endfunction

  function automatic logic [DataW-1:0] xorshr(logic [DataW-1:0] x, int sh);
    return x ^ (x >> sh);
  endfunction

endpackage

/* hw/rtl/ubpu_count.sv */
// ----------------------------------------------------------------------------
// Unary bit primitive unit counter
// Two-stage bit counter: per-byte counts first, then the combined
// leading-zero, trailing-zero and population counts, or the floor log2 and bit width, selected by operation.
// ----------------------------------------------------------------------------
module ubpu_count (
  input  logic                            clk_i,
  input  ubpu_pkg::stage_en_t             en_i,
  input  logic [ubpu_pkg::DataW-1:0]      operand_i,
  input  logic [ubpu_pkg::OpW-1:0]        op_i,
  output logic [ubpu_pkg::CntW-1:0]       cnt_o
);

  logic [ubpu_pkg::ChunkCntW-1:0] lz_q  [ubpu_pkg::NumChunks];
  logic [ubpu_pkg::ChunkCntW-1:0] tz_q  [ubpu_pkg::NumChunks];
  logic [ubpu_pkg::ChunkCntW-1:0] pop_q [ubpu_pkg::NumChunks];
  logic [ubpu_pkg::CntW-1:0]      lz_tot, tz_tot, pop_tot, cnt_d, cnt_q;
  logic                           lz_done, tz_done, zero;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int c = 0; c < ubpu_pkg::NumChunks; c++) begin
        lz_q[c]  <= ubpu_pkg::lz8(operand_i[c*ubpu_pkg::ChunkW +: ubpu_pkg::ChunkW]);
        tz_q[c]  <= ubpu_pkg::tz8(operand_i[c*ubpu_pkg::ChunkW +: ubpu_pkg::ChunkW]);
        pop_q[c] <= ubpu_pkg::pop8(operand_i[c*ubpu_pkg::ChunkW +: ubpu_pkg::ChunkW]);
      end
    end
  end

  always_comb begin
    lz_tot  = '0;
    tz_tot  = '0;
    pop_tot = '0;
    lz_done = 1'b0;
    tz_done = 1'b0;
    for (int c = ubpu_pkg::NumChunks - 1; c >= 0; c--) begin
      if (!lz_done) begin
        lz_tot = lz_tot + ubpu_pkg::CntW'(lz_q[c]);
        if (lz_q[c] != ubpu_pkg::ChunkCntW'(ubpu_pkg::ChunkW)) begin
          lz_done = 1'b1;
        end
      end
    end
    for (int c = 0; c < ubpu_pkg::NumChunks; c++) begin
      if (!tz_done) begin
        tz_tot = tz_tot + ubpu_pkg::CntW'(tz_q[c]);
        if (tz_q[c] != ubpu_pkg::ChunkCntW'(ubpu_pkg::ChunkW)) begin
          tz_done = 1'b1;
        end
      end
    end
    for (int c = 0; c < ubpu_pkg::NumChunks; c++) begin
      pop_tot = pop_tot + ubpu_pkg::CntW'(pop_q[c]);
    end
    zero = !lz_done;
    case (op_i)
      ubpu_pkg::OpIlog2:    cnt_d = zero ? '0 : ubpu_pkg::CntW'(ubpu_pkg::DataW - 1) - lz_tot;
      ubpu_pkg::OpBitWidth: cnt_d = zero ? '0 : ubpu_pkg::CntW'(ubpu_pkg::DataW) - lz_tot;
      ubpu_pkg::OpPopcount: cnt_d = pop_tot;
      ubpu_pkg::OpClz:      cnt_d = lz_tot;
      ubpu_pkg::OpCtz:      cnt_d = tz_tot;
      default:              cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

/* hw/rtl/ubpu_mul64lo.sv */
// ----------------------------------------------------------------------------
// Unary bit primitive unit low-half multiplier
// Forms the low 64 bits of a 64 by 64 product from three registered
// 32 by 32 partial products and sums them combinationally after the register.
// ----------------------------------------------------------------------------
module ubpu_mul64lo (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ubpu_pkg::DataW-1:0]   a_i,
  input  logic [ubpu_pkg::DataW-1:0]   m_i,
  output logic [ubpu_pkg::DataW-1:0]   prod_o
);

  localparam int HalfW = ubpu_pkg::DataW / 2;

  logic [ubpu_pkg::DataW-1:0] ll_d, ll_q;
  logic [HalfW-1:0]           hl_d, hl_q, lh_d, lh_q;

  assign ll_d = ubpu_pkg::DataW'(a_i[HalfW-1:0]) * ubpu_pkg::DataW'(m_i[HalfW-1:0]);
  assign hl_d = a_i[ubpu_pkg::DataW-1:HalfW] * m_i[HalfW-1:0];
  assign lh_d = a_i[HalfW-1:0] * m_i[ubpu_pkg::DataW-1:HalfW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      hl_q <= hl_d;
      lh_q <= lh_d;
    end
  end

  assign prod_o = ll_q + {hl_q + lh_q, {HalfW{1'b0}}};

endmodule

/* hw/rtl/unary_bit_primitive_unit.sv */
// ----------------------------------------------------------------------------
// Unary bit primitive unit
// Five-stage pipeline giving floor log2, bit width, population count,
// leading and trailing zero counts, or the 64-bit mix of one column element.
// ----------------------------------------------------------------------------
// Requests enter on in_req_i with in_valid_i and in_ready_o; responses leave
// on out_rsp_o with out_valid_o and out_ready_i. Each request gives exactly
// one response, in order, with out_last copied from in_last.
// A request passes through the stage registers in order, the last being the
// output register that drives out_rsp_o. A new request is taken every cycle
// unless a stall has filled the pipeline; the depth is set by the two
// registered 64-bit multiplications of the mix path.
// When the receiver holds out_ready_i low, each stage keeps its contents and
// empty stages ahead of the stall still fill, so in_ready_o drops only once
// all five stages hold a request. Nothing is dropped or repeated.
// Reset clears every stage valid bit, so the pipeline comes up empty and
// ready; the data registers are not reset.
// ----------------------------------------------------------------------------
module unary_bit_primitive_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ubpu_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ubpu_pkg::rsp_t   out_rsp_o
);

  localparam int NS = ubpu_pkg::NumStages;

  logic [NS-1:0]              vld_q, rdy;
  ubpu_pkg::stage_en_t        en;
  logic [ubpu_pkg::OpW-1:0]   op_q   [NS-1];
  logic                       last_q [NS-1];
  logic [ubpu_pkg::DataW-1:0] y1_d, y1_q, y2_d, y2_q, prod1, prod2, mix_res;
  logic [ubpu_pkg::CntW-1:0]  cnt_s2, cnt_s3_q, cnt_s4_q;
  ubpu_pkg::rsp_t             out_d, out_q;

  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      op_q[0]   <= in_req_i.op;
      last_q[0] <= in_req_i.in_last;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        op_q[k]   <= op_q[k-1];
        last_q[k] <= last_q[k-1];
      end
    end
  end

  assign y1_d = ubpu_pkg::xorshr(in_req_i.operand_value + ubpu_pkg::MixGamma,
                                 ubpu_pkg::MixShift1);

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      y1_q <= y1_d;
    end
  end

  ubpu_count u_count (
    .clk_i     (clk_i),
    .en_i      (en),
    .operand_i (in_req_i.operand_value),
    .op_i      (op_q[0]),
    .cnt_o     (cnt_s2)
  );

  ubpu_mul64lo u_mul1 (
    .clk_i  (clk_i),
    .en_i   (en.s2),
    .a_i    (y1_q),
    .m_i    (ubpu_pkg::MixMul1),
    .prod_o (prod1)
  );

  assign y2_d = ubpu_pkg::xorshr(prod1, ubpu_pkg::MixShift2);

  always_ff @(posedge clk_i) begin
    if (en.s3) begin
      y2_q     <= y2_d;
      cnt_s3_q <= cnt_s2;
    end
    if (en.s4) begin
      cnt_s4_q <= cnt_s3_q;
    end
  end

  ubpu_mul64lo u_mul2 (
    .clk_i  (clk_i),
    .en_i   (en.s4),
    .a_i    (y2_q),
    .m_i    (ubpu_pkg::MixMul2),
    .prod_o (prod2)
  );

  assign mix_res = ubpu_pkg::xorshr(prod2, ubpu_pkg::MixShift3);

  always_comb begin
    out_d.out_last     = last_q[NS-2];
    out_d.result_value = (op_q[NS-2] == ubpu_pkg::OpMix64) ? mix_res
                                                           : ubpu_pkg::DataW'(cnt_s4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en.s5) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_rsp_o   = out_q;

endmodule

/* hw/rtl/ubpu_checker.sv */
// ----------------------------------------------------------------------------
// Unary bit primitive unit checker
// Port-level checks on flow control and latency, bound to the top level.
// ----------------------------------------------------------------------------
`include "unary_bit_primitive_unit_macros.svh"

module ubpu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input ubpu_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ubpu_pkg::rsp_t out_rsp_o
);

  `UBPU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o), "response changed while stalled")
  `UBPU_ASSERT(a_full_only_on_stall, !in_ready_o |-> out_valid_o && !out_ready_i, "request refused without a full stalled pipeline")
  `UBPU_ASSERT(a_ready_through, out_ready_i |-> in_ready_o, "request refused while the receiver is ready")
  `UBPU_ASSERT(a_latency, in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o, "response missing after five free cycles")

endmodule

bind unary_bit_primitive_unit ubpu_checker u_checker (.*);
